>>> rtl/core/sri_pkg.sv
package sri_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned DataW = 32;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StEnds   = 12'b000000000010,
    StEndsW  = 12'b000000000100,
    StCheck  = 12'b000000001000,
    StSearch = 12'b000000010000,
    StSrchW  = 12'b000000100000,
    StPair   = 12'b000001000000,
    StPairW  = 12'b000010000000,
    StDiv1   = 12'b000100000000,
    StDiv2   = 12'b001000000000,
    StDiv2W  = 12'b010000000000,
    StOut    = 12'b100000000000
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

>>> rtl/core/sri_ram.sv
module sri_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/sri_div.sv
module sri_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output sri_pkg::div_ctl_t ctl
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] dvs;
  logic [CntW-1:0] cnt;
  logic [W:0] trial;
  logic [W:0] shifted;

  assign shifted = {rem, quo[W-1]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign ctl.start = start;
  assign ctl.busy = (cnt != '0);

endmodule

>>> rtl/core/spectrum_ratio_interpolator_top.sv
// channel | signals                   | direction
// in      | in_valid in_stall op first xpos level | into block
// out     | out_valid out_stall out_xpos percent   | out of block
// a load is taken while idle; a query stalls the input through the memory round trips
// of the binary search and the shared bit-serial 64-bit divider, used up to twice;
// a miss or a query without a step skips part of this work
// rst clears the point count and control; table contents are not cleared
// a result waits in the output register while new requests are taken; a query
// that finishes stalls the input until the output register is free
module spectrum_ratio_interpolator_top #(
  parameter int unsigned MAX_POINTS = sri_pkg::MaxPoints,
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic        first,
  input  logic [31:0] xpos,
  input  logic signed [31:0] level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_xpos,
  output logic signed [31:0] percent
);

  sri_pkg::state_t state;
  logic [CW-1:0] count;
  logic [31:0] tx;
  logic signed [31:0] ref_lvl;
  logic [31:0] x0, y0;
  logic asc;
  logic [CW-1:0] base, len;
  logic [CW-1:0] idx;
  logic phase;
  logic [31:0] xl, yl;
  logic signed [63:0] interp;
  logic neg;
  logic [32:0] dx_r;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0] pos_q, lvl_q;
  logic accept;

  logic div_start;
  logic div_start_next;
  logic [63:0] div_a, div_b, div_q;
  sri_pkg::div_ctl_t div_ctl;
  logic out_load;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != sri_pkg::StIdle);
  assign we = accept && (op == sri_pkg::OpLoad) && (first || count < CW'(MAX_POINTS));
  assign waddr = first ? '0 : count[AW-1:0];

  sri_ram #(.Width(32), .Depth(MAX_POINTS)) u_pos (
    .clk, .we, .waddr, .wdata(xpos), .raddr, .rdata(pos_q));
  sri_ram #(.Width(32), .Depth(MAX_POINTS)) u_lvl (
    .clk, .we, .waddr, .wdata(level), .raddr, .rdata(lvl_q));

  sri_div #(.W(64)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .ctl(div_ctl));

  logic [CW-1:0] half, mid;
  logic behind;
  assign half = len >> 1;
  assign mid = base + half;
  assign behind = asc ? (pos_q < tx) : (pos_q > tx);

  always_comb begin
    raddr = '0;
    case (state)
      sri_pkg::StEnds: raddr = '0;
      sri_pkg::StEndsW: raddr = AW'(count - 1'b1);
      sri_pkg::StSearch: raddr = mid[AW-1:0];
      sri_pkg::StPair: raddr = phase ? idx[AW-1:0] : AW'(idx - 1'b1);
      sri_pkg::StPairW: raddr = idx[AW-1:0];
      default: raddr = '0;
    endcase
  end

  logic [32:0] dx_c, dt_c;
  logic [31:0] dtm_c;
  logic signed [32:0] dy_c;
  logic [32:0] ymag_c;
  logic signed [63:0] q_signed;
  logic signed [63:0] num_c;
  logic signed [63:0] pct_c;
  logic [63:0] num_mag;
  logic num_neg;

  assign dx_c = (pos_q >= xl) ? {1'b0, pos_q - xl} : {1'b0, xl - pos_q};
  assign dt_c = (tx >= xl) ? {1'b0, tx - xl} : {1'b0, xl - tx};
  assign dtm_c = (dt_c > dx_c) ? dx_c[31:0] : dt_c[31:0];
  assign dy_c = $signed({lvl_q[31], lvl_q}) - $signed({yl[31], yl});
  assign ymag_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
  assign q_signed = neg ? -$signed(div_q) : $signed(div_q);
  assign num_c = interp * 64'sd6553600;
  assign num_neg = num_c[63];
  assign num_mag = num_neg ? 64'(-num_c) : 64'(num_c);
  assign pct_c = neg ? -$signed(div_q) : $signed(div_q);

  assign div_start_next = ((state == sri_pkg::StPairW) && phase && (dx_c != '0))
                          || (state == sri_pkg::StDiv2);
  assign out_load = (state == sri_pkg::StOut) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sri_pkg::StIdle;
      count <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= div_start_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        sri_pkg::StIdle: begin
          if (accept) begin
            tx <= xpos;
            ref_lvl <= level;
            if (op == sri_pkg::OpLoad) begin
              if (first) count <= CW'(1);
              else if (count < CW'(MAX_POINTS)) count <= count + 1'b1;
            end else if (count != '0) begin
              state <= sri_pkg::StEnds;
            end
          end
        end
        sri_pkg::StEnds: state <= sri_pkg::StEndsW;
        sri_pkg::StEndsW: begin
          x0 <= pos_q;
          y0 <= lvl_q;
          state <= sri_pkg::StCheck;
        end
        sri_pkg::StCheck: begin
          asc <= x0 < pos_q;
          base <= '0;
          len <= count;
          if ((tx < ((x0 < pos_q) ? x0 : pos_q)) || (tx > ((x0 < pos_q) ? pos_q : x0))) begin
            state <= sri_pkg::StIdle;
          end else begin
            state <= sri_pkg::StSearch;
          end
        end
        sri_pkg::StSearch: begin
          if (len == '0) begin
            idx <= base;
            phase <= 1'b0;
            if (base == '0) begin
              interp <= 64'($signed(y0));
              state <= sri_pkg::StDiv1;
            end else begin
              state <= sri_pkg::StPair;
            end
          end else begin
            state <= sri_pkg::StSrchW;
          end
        end
        sri_pkg::StSrchW: begin
          if (behind) begin
            base <= mid + 1'b1;
            len <= len - half - 1'b1;
          end else begin
            len <= half;
          end
          state <= sri_pkg::StSearch;
        end
        sri_pkg::StPair: state <= sri_pkg::StPairW;
        sri_pkg::StPairW: begin
          if (!phase) begin
            if (idx >= count) begin
              interp <= 64'($signed(lvl_q));
              phase <= 1'b1;
              state <= sri_pkg::StDiv1;
              idx <= '0;
            end else begin
              xl <= pos_q;
              yl <= lvl_q;
              phase <= 1'b1;
              state <= sri_pkg::StPair;
            end
          end else begin
            dx_r <= dx_c;
            neg <= dy_c[32];
            interp <= 64'($signed(yl));
            if (dx_c != '0) begin
              div_a <= 64'(ymag_c[31:0]) * 64'(dtm_c);
              div_b <= 64'(dx_c);
            end
            state <= sri_pkg::StDiv1;
          end
        end
        sri_pkg::StDiv1: begin
          if (!div_ctl.busy && !div_start) begin
            if (phase && idx != '0 && dx_r != '0) begin
              interp <= interp + q_signed;
            end
            idx <= '0;
            state <= sri_pkg::StDiv2;
          end
        end
        sri_pkg::StDiv2: begin
          neg <= num_neg;
          div_a <= num_mag;
          div_b <= 64'(ref_lvl);
          state <= sri_pkg::StDiv2W;
        end
        sri_pkg::StDiv2W: begin
          if (!div_ctl.busy && !div_start) state <= sri_pkg::StOut;
        end
        sri_pkg::StOut: begin
          if (out_load) begin
            out_xpos <= tx;
            if (ref_lvl <= 0) percent <= '0;
            else if (pct_c > 64'sd2147483647) percent <= 32'sh7fffffff;
            else if (pct_c < -64'sd2147483648) percent <= 32'sh80000000;
            else percent <= pct_c[31:0];
            state <= sri_pkg::StIdle;
          end
        end
        default: state <= sri_pkg::StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != sri_pkg::StIdle) |-> in_stall)
    else $error("accepting while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(percent) && $stable(out_xpos))
    else $error("result dropped");
`endif

endmodule

>>> tb/sv/tb_spectrum_ratio_interpolator_top.sv
module tb_spectrum_ratio_interpolator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPts = sri_pkg::MaxPoints;
  localparam int CycleLimit = 1500000;

  typedef enum logic [1:0] {ByModel, NoResult, Typed} chk_t;

  typedef struct packed {
    logic        op;
    logic        first;
    logic [31:0] x;
    logic [31:0] lvl;
    chk_t        chk;
    logic [31:0] pct;
  } row_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] pct;
  } ratio_t;

  localparam row_t Rows [0:23] = '{
    '{sri_pkg::OpQuery, 1'b0, 32'h0000_0005, 32'h0000_0001, NoResult, 32'h0},
    '{sri_pkg::OpLoad,  1'b1, 32'h0001_0000, 32'h0001_0000, NoResult, 32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0001_0000, 32'h0001_0000, Typed,    32'd6553600},
    '{sri_pkg::OpQuery, 1'b0, 32'h0001_0000, 32'h0000_0000, Typed,    32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0001_0000, 32'h8000_0000, Typed,    32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0002_0000, 32'h0001_0000, NoResult, 32'h0},
    '{sri_pkg::OpLoad,  1'b0, 32'h0005_0000, 32'h0003_0000, NoResult, 32'h0},
    '{sri_pkg::OpLoad,  1'b0, 32'h0009_0000, 32'h7FFF_FFFF, NoResult, 32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0001_0000, 32'h0000_0001, Typed,    32'h7FFF_FFFF},
    '{sri_pkg::OpQuery, 1'b0, 32'h0009_0000, 32'h7FFF_FFFF, Typed,    32'd6553600},
    '{sri_pkg::OpQuery, 1'b0, 32'h0003_0000, 32'h0001_0000, ByModel,  32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'hFFFF_FFFF, 32'h0001_0000, NoResult, 32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0000_0000, 32'h0001_0000, NoResult, 32'h0},
    '{sri_pkg::OpLoad,  1'b1, 32'hFFFF_FFFF, 32'h8000_0000, NoResult, 32'h0},
    '{sri_pkg::OpLoad,  1'b0, 32'h8000_0000, 32'h0000_0000, NoResult, 32'h0},
    '{sri_pkg::OpLoad,  1'b0, 32'h0000_0000, 32'h7FFF_FFFF, NoResult, 32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0000_0000, 32'h0001_0000, ByModel,  32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'hFFFF_FFFF, 32'h0000_0001, Typed,    32'h8000_0000},
    '{sri_pkg::OpQuery, 1'b0, 32'h4000_0000, 32'h7FFF_FFFF, ByModel,  32'h0},
    '{sri_pkg::OpQuery, 1'b1, 32'h8000_0000, 32'h0001_0000, ByModel,  32'h0},
    '{sri_pkg::OpLoad,  1'b1, 32'h0000_0100, 32'hFFFF_FFFB, NoResult, 32'h0},
    '{sri_pkg::OpLoad,  1'b0, 32'h0000_0300, 32'h0000_0007, NoResult, 32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0000_0200, 32'h0000_0003, ByModel,  32'h0},
    '{sri_pkg::OpQuery, 1'b0, 32'h0000_0101, 32'h7FFF_FFFF, ByModel,  32'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic        first = 1'b0;
  logic [31:0] xpos = '0;
  logic signed [31:0] level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_xpos;
  logic signed [31:0] percent;

  logic [31:0] pos_mem [MaxPts];
  logic [31:0] lvl_mem [MaxPts];
  int unsigned npts = 0;

  ratio_t ratio_q[$];
  int errors = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_checked = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  logic hold_go = 1'b0;
  int hold_left = 0;

  spectrum_ratio_interpolator_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .first(first), .xpos(xpos), .level(level),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_xpos(out_xpos), .percent(percent)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_spectrum_ratio_interpolator_top NOT OK");
      $finish;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) hold_left <= 400;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    ratio_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (ratio_q.size() == 0) begin
          $error("unexpected result x=%h percent=%h", out_xpos, percent);
          errors++;
        end else begin
          e = ratio_q.pop_front();
          n_checked++;
          if (out_xpos !== e.x) begin
            $error("out_xpos expected %h actual %h", e.x, out_xpos);
            errors++;
          end
          if (percent !== e.pct) begin
            $error("percent expected %h actual %h", e.pct, percent);
            errors++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // predicts one request; returns 1 when a result is due
  function automatic bit transmittance(input bit o, input bit f, input logic [31:0] x,
                                       input logic [31:0] l, output logic [31:0] px);
    int unsigned last, base, len, half, mid, idx, lo, hi;
    logic [31:0] x0, xn, xmin, xmax, v;
    bit asc, behind;
    longint yl, yh, dy, interp, pct, lv;
    longint unsigned dx, dt, mag, q;
    px = '0;
    if (o == sri_pkg::OpLoad) begin
      if (f) begin
        pos_mem[0] = x;
        lvl_mem[0] = l;
        npts = 1;
      end else if (npts < MaxPts) begin
        pos_mem[npts] = x;
        lvl_mem[npts] = l;
        npts++;
      end
      return 1'b0;
    end
    if (npts == 0) return 1'b0;
    last = npts - 1;
    x0 = pos_mem[0];
    xn = pos_mem[last];
    asc = x0 < xn;
    xmin = asc ? x0 : xn;
    xmax = asc ? xn : x0;
    if (x < xmin || x > xmax) return 1'b0;
    base = 0;
    len = npts;
    while (len > 0) begin
      half = len / 2;
      mid = base + half;
      v = pos_mem[mid];
      behind = asc ? (v < x) : (v > x);
      if (behind) begin
        base = mid + 1;
        len = len - half - 1;
      end else begin
        len = half;
      end
    end
    idx = base;
    if (idx == 0) interp = longint'($signed(lvl_mem[0]));
    else if (idx >= npts) interp = longint'($signed(lvl_mem[last]));
    else begin
      lo = idx - 1;
      hi = idx;
      yl = longint'($signed(lvl_mem[lo]));
      yh = longint'($signed(lvl_mem[hi]));
      dx = (pos_mem[hi] >= pos_mem[lo]) ? pos_mem[hi] - pos_mem[lo]
                                         : pos_mem[lo] - pos_mem[hi];
      dt = (x >= pos_mem[lo]) ? x - pos_mem[lo] : pos_mem[lo] - x;
      dy = yh - yl;
      if (dx == 0) interp = yl;
      else begin
        if (dt > dx) dt = dx;
        mag = (dy < 0) ? longint'(-dy) : longint'(dy);
        q = (mag * dt) / dx;
        interp = (dy < 0) ? yl - longint'(q) : yl + longint'(q);
      end
    end
    lv = longint'($signed(l));
    if (lv > 0) begin
      pct = (interp * 100 * 65536) / lv;
      if (pct > 64'sh7FFF_FFFF) pct = 64'sh7FFF_FFFF;
      if (pct < -64'sh8000_0000) pct = -64'sh8000_0000;
    end else begin
      pct = 0;
    end
    px = pct[31:0];
    return 1'b1;
  endfunction

  task automatic offer(input bit o, input bit f, input logic [31:0] x, input logic [31:0] l,
                       input chk_t c, input logic [31:0] p);
    logic [31:0] px;
    bit due;
    ratio_t item;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    first <= f;
    xpos <= x;
    level <= l;
    do @(posedge clk); while (in_stall);
    due = transmittance(o, f, x, l, px);
    if (o == sri_pkg::OpLoad) n_loads++;
    else n_queries++;
    if (c == Typed) begin
      item = '{x: x, pct: p};
      ratio_q.insert(ratio_q.size(), item);
    end else if (c == ByModel && due) begin
      item = '{x: x, pct: px};
      ratio_q.insert(ratio_q.size(), item);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ratio_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] ref_level();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'h8000_0000 | $urandom();
      2, 3: return $urandom_range(32'h7FFF_FFFF, 1);
      default: return $urandom_range(32'h0100_0000, 32'h0000_1000);
    endcase
  endfunction

  // one table of random points followed by queries on it
  task automatic table_round(input int k, input int nq);
    logic [31:0] xs[$];
    logic [31:0] tmp, lo, hi;
    int j;
    for (int i = 0; i < k; i++) xs.insert(xs.size(), $urandom());
    xs.sort();
    if ($urandom_range(1)) xs.reverse();
    if (k > 3 && $urandom_range(9) == 0) begin
      j = $urandom_range(k - 2, 1);
      tmp = xs[j];
      xs[j] = xs[j + 1];
      xs[j + 1] = tmp;
    end
    for (int i = 0; i < k; i++)
      offer(sri_pkg::OpLoad, i == 0, xs[i], $urandom(), ByModel, '0);
    lo = xs[0];
    hi = xs[k - 1];
    for (int i = 0; i < nq; i++) begin
      case ($urandom_range(9))
        0: tmp = $urandom();
        1: tmp = xs[$urandom_range(k - 1)];
        default: tmp = $urandom_range(hi, lo);
      endcase
      offer(sri_pkg::OpQuery, $urandom_range(1), tmp, ref_level(), ByModel, '0);
    end
  endtask

  task automatic random_phase(input int idle, input int stall, input int items);
    int start, k;
    idle_pct = idle;
    stall_pct = stall;
    start = n_loads + n_queries;
    while (n_loads + n_queries - start < items) begin
      k = ($urandom_range(19) == 0) ? $urandom_range(200, 60) : $urandom_range(16, 1);
      table_round(k, $urandom_range(12, 3));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (Rows[i])
      offer(Rows[i].op, Rows[i].first, Rows[i].x, Rows[i].lvl, Rows[i].chk, Rows[i].pct);
    drain();

    // receiver holds off while requests keep coming
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    table_round(8, 10);
    drain();

    random_phase(0, 0, 240);
    random_phase(45, 0, 240);
    random_phase(0, 45, 240);
    random_phase(25, 25, 240);

    drain();
    repeat (300) @(posedge clk);
    $display("covered %0d loads and %0d queries, %0d results compared",
             n_loads, n_queries, n_checked);
    $display("tables of 1 to 200 points, ascending, descending and out of order");
    if (errors == 0 && ratio_q.size() == 0) begin
      $display("tb_spectrum_ratio_interpolator_top OK");
    end else begin
      $display("tb_spectrum_ratio_interpolator_top NOT OK");
    end
    $finish;
  end

endmodule
